// File: sv/lfu_pkg.sv
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by every module of the block.
package lfu_pkg;

	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 16;
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int COUNT_W   = 16;
	localparam int TIME_W    = 32;
	localparam int FAULT_W   = 32;
	localparam int CFG_W     = 3;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(FRAMES);

	// register index of frames_in_use
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// one frame as read from the table
	typedef struct packed {
		logic                 valid;
		logic [PAGE_BITS-1:0] page;
		logic [COUNT_W-1:0]   count;
		logic [TIME_W-1:0]    load;
	} entry_t;

	// table write request; full = 0 writes the count only
	typedef struct packed {
		logic                 we;
		logic                 full;
		logic [FRAME_W-1:0]   idx;
		logic [PAGE_BITS-1:0] page;
		logic [COUNT_W-1:0]   count;
		logic [TIME_W-1:0]    load;
	} wr_t;

	// compare unit results for the frame under scan
	typedef struct packed {
		logic match;
		logic empty;
		logic less;
	} cmp_t;

endpackage

// File: sv/lfu_frame_table.sv
// Frame table: page, valid, use count and load time for each frame.
// Depends on lfu_pkg (entry_t, wr_t, widths).
module lfu_frame_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lfu_pkg::FRAME_W-1:0]   rd_idx,
	output lfu_pkg::entry_t               rd_entry,
	input  lfu_pkg::wr_t                  wr
);
	import lfu_pkg::*;

	logic                 valid_q [FRAMES];
	logic [PAGE_BITS-1:0] page_q  [FRAMES];
	logic [COUNT_W-1:0]   count_q [FRAMES];
	logic [TIME_W-1:0]    load_q  [FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAMES; k++) begin
				valid_q[k] <= 1'b0;
				count_q[k] <= '0;
				load_q[k]  <= '0;
			end
		end else if (wr.we) begin
			count_q[wr.idx] <= wr.count;
			if (wr.full) begin
				valid_q[wr.idx] <= 1'b1;
				load_q[wr.idx]  <= wr.load;
			end
		end
	end

	// page store has no reset; only read behind its valid bit
	always_ff @(posedge clk) begin
		if (wr.we && wr.full) begin
			page_q[wr.idx] <= wr.page;
		end
	end

	always_comb begin
		rd_entry.valid = valid_q[rd_idx];
		rd_entry.page  = page_q[rd_idx];
		rd_entry.count = count_q[rd_idx];
		rd_entry.load  = load_q[rd_idx];
	end

endmodule

// File: sv/lfu_compare_unit.sv
// Shared compare unit: page match, empty check and LFU/FIFO ordering.
// Depends on lfu_pkg (entry_t, cmp_t, widths).
module lfu_compare_unit (
	input  logic [lfu_pkg::PAGE_BITS-1:0] page,
	input  lfu_pkg::entry_t               entry,
	input  logic [lfu_pkg::COUNT_W-1:0]   best_count,
	input  logic [lfu_pkg::TIME_W-1:0]    best_load,
	output lfu_pkg::cmp_t                 cmp
);
	import lfu_pkg::*;

	always_comb begin
		cmp.match = entry.valid && (entry.page == page);
		cmp.empty = !entry.valid;
		// strictly fewer uses, or same uses and loaded earlier
		cmp.less  = (entry.count < best_count) ||
		            ((entry.count == best_count) && (entry.load < best_load));
	end

endmodule

// File: sv/lfu_page_replacement.sv
// Top level of the LFU page replacement block: sequencer, APB register
// and result registers. Depends on lfu_pkg, lfu_frame_table, lfu_compare_unit.
//
// One page reference is a transfer on start/page, taken when start is high
// and busy is low. The sequencer then walks the active frames one per
// cycle through a single compare unit, looking for the page while also
// noting the first empty frame and the least-used, oldest frame. The walk
// stops early on a hit. An update state follows that bumps the use count
// or loads the victim frame. The result (hit, frame, fault_count) shows for
// exactly one cycle with done high, registered after the update state;
// it cannot be stalled, so the receiver must take it then. busy drops in the
// cycle done is high, so a new reference can be taken then but not while a
// walk or update is in progress; the walk of one compare per cycle sets the
// pace, shorter on an early hit. frames_in_use sits at APB address 0; 0 acts
// as 1 and values above 4 act as 4. Write it only while busy is low. Use
// counts, load times and the fault count saturate at all ones.
module lfu_page_replacement (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfu_pkg::APB_AW-1:0]    paddr,
	input  logic [lfu_pkg::APB_DW-1:0]    pwdata,
	output logic [lfu_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// command
	input  logic                          start,
	input  logic [lfu_pkg::PAGE_BITS-1:0] page,
	output logic                          busy,
	// result
	output logic                          done,
	output logic                          hit,
	output logic [1:0]                    frame,
	output logic [lfu_pkg::FAULT_W-1:0]   fault_count
);
	import lfu_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]     cfg_q;
	logic [FRAME_W-1:0]   last;
	logic [FRAME_W-1:0]   idx_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0]   hit_count_q;
	logic                 empty_found_q;
	logic [FRAME_W-1:0]   empty_idx_q;
	logic [FRAME_W-1:0]   best_idx_q;
	logic [COUNT_W-1:0]   best_count_q;
	logic [TIME_W-1:0]    best_load_q;
	logic [TIME_W-1:0]    seq_q;
	logic [FAULT_W-1:0]   faults_q;
	logic                 done_q;
	logic                 res_hit_q;
	logic [FRAME_W-1:0]   res_frame_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 scan_stop;
	logic [FRAME_W-1:0]   slot;
	entry_t               rd_entry;
	wr_t                  wr;
	cmp_t                 cmp;

	// ---------------- APB register ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr && (paddr[APB_AW-1] == REG_FRAMES_IN_USE)) begin
			cfg_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1] == REG_FRAMES_IN_USE) begin
			prdata = APB_DW'(cfg_q);
		end
	end

	// last active frame index: zero acts as one, large values clamp
	always_comb begin
		if (cfg_q == '0) begin
			last = '0;
		end else if (cfg_q > CFG_W'(FRAMES)) begin
			last = FRAME_W'(FRAMES - 1);
		end else begin
			last = FRAME_W'(cfg_q - CFG_W'(1));
		end
	end

	// ---------------- datapath units ----------------
	lfu_frame_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.rd_entry (rd_entry),
		.wr       (wr)
	);

	lfu_compare_unit u_cmp (
		.page       (page_q),
		.entry      (rd_entry),
		.best_count (best_count_q),
		.best_load  (best_load_q),
		.cmp        (cmp)
	);

	// ---------------- sequencer ----------------
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		scan_stop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_stop = cmp.match || (idx_q == last);
				if (scan_stop) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan bookkeeping; one frame per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			hit_q         <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (accept) begin
			idx_q         <= '0;
			hit_q         <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (cmp.match) begin
				hit_q <= 1'b1;
			end else if (cmp.empty && !empty_found_q) begin
				empty_found_q <= 1'b1;
			end
			if (!scan_stop) begin
				idx_q <= idx_q + FRAME_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page;
		end
		if (state_q == ST_SCAN) begin
			if (cmp.match) begin
				hit_idx_q   <= idx_q;
				hit_count_q <= rd_entry.count;
			end
			if (cmp.empty && !empty_found_q) begin
				empty_idx_q <= idx_q;
			end
			if ((idx_q == '0) || cmp.less) begin
				best_idx_q   <= idx_q;
				best_count_q <= rd_entry.count;
				best_load_q  <= rd_entry.load;
			end
		end
	end

	// ---------------- update ----------------
	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (empty_found_q) begin
			slot = empty_idx_q;
		end else begin
			slot = best_idx_q;
		end
	end

	always_comb begin
		wr.we    = (state_q == ST_UPDATE);
		wr.full  = !hit_q;
		wr.idx   = slot;
		wr.page  = page_q;
		wr.load  = seq_q;
		if (hit_q) begin
			wr.count = (hit_count_q < COUNT_MAX) ? hit_count_q + COUNT_W'(1) : hit_count_q;
		end else begin
			wr.count = COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			faults_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
			if (state_q == ST_UPDATE) begin
				if (seq_q < TIME_MAX) begin
					seq_q <= seq_q + TIME_W'(1);
				end
				if (!hit_q && (faults_q < FAULT_MAX)) begin
					faults_q <= faults_q + FAULT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			res_hit_q   <= hit_q;
			res_frame_q <= slot;
		end
	end

	assign done        = done_q;
	assign hit         = res_hit_q;
	assign frame       = 2'(res_frame_q);
	assign fault_count = faults_q;

`ifndef SYNTHESIS
	a_update_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> done_q)
		else $error("result strobe missing after update");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while still busy");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last))
		else $error("scan index beyond active frames");

	a_miss_counts_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !res_hit_q) |-> (faults_q != '0))
		else $error("miss reported with zero fault count");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted reference did not start a scan");
`endif

endmodule

// File: test/lfu_page_replacement_test.sv
`timescale 1ns / 100ps
// Self-checking bench for lfu_page_replacement: directed rows, then random phases.
// Depends on lfu_pkg and the lfu_page_replacement RTL; needs nothing else.
module lfu_page_replacement_test;
	import lfu_pkg::*;

	localparam int WATCHDOG_LIMIT = 400;   // cycles with no transfer before giving up
	localparam int DRAIN_CYCLES   = 16;    // quiet time after the last result
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 75;
	localparam int PRINT_CAP      = 50;

	localparam logic [APB_AW-1:0] FRAMES_ADDR   = APB_AW'(4 * REG_FRAMES_IN_USE);
	// first byte address past the register map; writes there must be dropped
	localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(4);

	typedef enum logic [1:0] {
		ROW_REF,
		ROW_CFG,
		ROW_CFG_UNMAPPED
	} row_kind_e;

	typedef struct packed {
		logic               hit;
		logic [1:0]         frame;
		logic [FAULT_W-1:0] faults;
	} result_t;

	// one line of the directed stimulus; res is used only when typed is set
	typedef struct packed {
		row_kind_e   kind;
		logic [31:0] value;
		logic        typed;
		result_t     res;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 start;
	logic [PAGE_BITS-1:0] page;
	logic                 busy;
	logic                 done;
	logic                 hit;
	logic [1:0]           frame;
	logic [FAULT_W-1:0]   fault_count;

	// predictor state: our own copy of the frame table and counters
	logic [PAGE_BITS-1:0] fr_page   [FRAMES];
	logic                 fr_valid  [FRAMES];
	logic [COUNT_W-1:0]   fr_uses   [FRAMES];
	logic [TIME_W-1:0]    fr_loaded [FRAMES];
	logic [TIME_W-1:0]    ref_index;
	logic [FAULT_W-1:0]   fault_total;
	logic [CFG_W-1:0]     frames_cfg;

	result_t pending_results [$];   // results owed by the block, oldest first
	result_t oldest;
	result_t predicted;
	logic    use_typed;             // current reference carries a hand-written result
	result_t typed_res;
	int      mismatch_count;
	int      idle_cycles;

	lfu_page_replacement uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.page        (page),
		.busy        (busy),
		.done        (done),
		.hit         (hit),
		.frame       (frame),
		.fault_count (fault_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// LFU lookup/replace for one reference; updates the predictor state.
	function automatic result_t predict_reference(input logic [PAGE_BITS-1:0] pg);
		int      n;
		int      k;
		int      slot;
		result_t r;
		// 0 acts as 1, anything past the table acts as the full table
		n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
		slot = -1;
		for (k = 0; k < n; k++)
			if (slot < 0 && fr_valid[k] && fr_page[k] == pg)
				slot = k;
		r.hit = (slot >= 0);
		if (r.hit) begin
			if (fr_uses[slot] != COUNT_MAX)
				fr_uses[slot]++;
		end else begin
			// lowest empty frame first
			for (k = 0; k < n; k++)
				if (slot < 0 && !fr_valid[k])
					slot = k;
			// else least used, then oldest load, then lowest index
			if (slot < 0) begin
				slot = 0;
				for (k = 1; k < n; k++)
					if (fr_uses[k] < fr_uses[slot] ||
					    (fr_uses[k] == fr_uses[slot] && fr_loaded[k] < fr_loaded[slot]))
						slot = k;
			end
			fr_page[slot]   = pg;
			fr_valid[slot]  = 1'b1;
			fr_uses[slot]   = COUNT_W'(1);
			fr_loaded[slot] = ref_index;
			if (fault_total != FAULT_MAX)
				fault_total++;
		end
		if (ref_index != TIME_MAX)
			ref_index++;
		r.frame  = 2'(slot);
		r.faults = fault_total;
		return r;
	endfunction

	function automatic row_t mk_row(input row_kind_e kind, input logic [31:0] value,
	                                input logic typed, input logic h, input logic [1:0] f,
	                                input logic [FAULT_W-1:0] faults);
		row_t row;
		row.kind       = kind;
		row.value      = value;
		row.typed      = typed;
		row.res.hit    = h;
		row.res.frame  = f;
		row.res.faults = faults;
		return row;
	endfunction

	// sender idle: a gap with start low about one time in four, if idle_ok is set
	function automatic int pick_gap(input bit idle_ok);
		if (idle_ok && $urandom_range(0, 3) == 0)
			return int'($urandom_range(1, 11));
		return 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
	                               input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Present one reference and hold it until the transfer happens.
	// Left right after a rising edge; start stays high when gap is 0.
	task automatic issue_ref(input logic [PAGE_BITS-1:0] pg, input int gap,
	                         input logic typed, input result_t typed_val);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start     <= 1'b1;
		page      <= pg;
		use_typed = typed;
		typed_res = typed_val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and wait for every owed result; the block is then idle.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// APB write: setup, then access; the register takes it on the access edge
	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == FRAMES_ADDR)
			frames_cfg = data[CFG_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result checker and predictor hook. The result of the previous reference
	// can land on the same edge as the next transfer, so check first, then push.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none owed", 32'h0, {31'h0, hit});
				end else begin
					oldest = pending_results.pop_front();
					if (hit !== oldest.hit)
						report_mismatch("hit", {31'h0, oldest.hit}, {31'h0, hit});
					if (frame !== oldest.frame)
						report_mismatch("frame", {30'h0, oldest.frame}, {30'h0, frame});
					if (fault_count !== oldest.faults)
						report_mismatch("fault_count", oldest.faults, fault_count);
				end
			end
			if (start && !busy) begin
				predicted = predict_reference(page);
				pending_results.push_back(use_typed ? typed_res : predicted);
			end
		end
	end

	// Watchdog: too long with no transfer on either side ends the run.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		row_t                 rows [$];
		logic [PAGE_BITS-1:0] pool [8];
		int                   pool_n;
		int                   active;
		int                   phase;
		int                   i;
		int                   r;
		bit                   idle_ok;
		logic [CFG_W-1:0]     cfg;
		logic [PAGE_BITS-1:0] pg;
		result_t              none;

		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		start     = 1'b0;
		page      = '0;
		use_typed = 1'b0;
		typed_res = '0;
		none      = '0;
		mismatch_count = 0;

		// predictor starts from the reset state
		for (i = 0; i < FRAMES; i++) begin
			fr_page[i]   = '0;
			fr_valid[i]  = 1'b0;
			fr_uses[i]   = '0;
			fr_loaded[i] = '0;
		end
		ref_index   = '0;
		fault_total = '0;
		frames_cfg  = CFG_RESET;

		// Directed rows. From reset all four frames are in use: the first
		// references fill empty frames from index 0 up, so those results are
		// written out. Later rows lean on the predictor.
		rows.push_back(mk_row(ROW_REF, 32'h0000, 1'b1, 1'b0, 2'd0, 32'd1));
		rows.push_back(mk_row(ROW_REF, 32'hFFFF, 1'b1, 1'b0, 2'd1, 32'd2));
		rows.push_back(mk_row(ROW_REF, 32'h0000, 1'b1, 1'b1, 2'd0, 32'd2));
		rows.push_back(mk_row(ROW_REF, 32'h0001, 1'b1, 1'b0, 2'd2, 32'd3));
		rows.push_back(mk_row(ROW_REF, 32'h8000, 1'b1, 1'b0, 2'd3, 32'd4));
		// table full: least used, oldest load goes
		rows.push_back(mk_row(ROW_REF, 32'h7FFF, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h0001, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'hFFFF, 1'b0, 1'b0, 2'd0, 32'd0));
		// shrink to one frame, junk in the upper data bits
		rows.push_back(mk_row(ROW_CFG, 32'hFFFF_FFF9, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h8000, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h8000, 1'b0, 1'b0, 2'd0, 32'd0));
		// zero frames behaves as one
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h0001, 1'b0, 1'b0, 2'd0, 32'd0));
		// too many behaves as four; frames outside the range kept their pages
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0007, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h8000, 1'b0, 1'b0, 2'd0, 32'd0));
		// write past the register map is dropped
		rows.push_back(mk_row(ROW_CFG_UNMAPPED, 32'h0000_0001, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h1234, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0005, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'hAAAA, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0002, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h5555, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'hAAAA, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0003, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_REF, 32'h0000, 1'b0, 1'b0, 2'd0, 32'd0));
		rows.push_back(mk_row(ROW_CFG, 32'h0000_0004, 1'b0, 1'b0, 2'd0, 32'd0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_REF: begin
					issue_ref(rows[i].value[PAGE_BITS-1:0], pick_gap(1'b1),
					          rows[i].typed, rows[i].res);
				end
				ROW_CFG: begin
					settle();
					write_reg(FRAMES_ADDR, rows[i].value);
				end
				default: begin
					settle();
					write_reg(UNMAPPED_ADDR, rows[i].value);
				end
			endcase
		end

		// Random phases: one frame count per phase, references drawn mostly
		// from a small pool sized against the active frames so hits, fills and
		// evictions all happen; the rest is wide noise and the page extremes.
		// The last two phases run back to back with no idling.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       cfg = 3'd1;
				1:       cfg = 3'd4;
				2:       cfg = 3'd0;
				3:       cfg = 3'd7;
				default: cfg = CFG_W'($urandom_range(0, 7));
			endcase
			settle();
			write_reg(FRAMES_ADDR, ($urandom & 32'hFFFF_FFF8) | 32'(cfg));
			if (phase == 5)
				write_reg(UNMAPPED_ADDR, $urandom);
			active = (cfg == 0) ? 1 : ((cfg > FRAMES) ? FRAMES : int'(cfg));
			pool_n = $urandom_range(1, active + 3);
			for (i = 0; i < pool_n; i++)
				pool[i] = PAGE_BITS'($urandom);
			idle_ok = (phase < PHASES - 2) && ($urandom_range(0, 2) != 0);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					pg = pool[$urandom_range(0, pool_n - 1)];
				else if (r < 92)
					pg = PAGE_BITS'($urandom);
				else if (r < 96)
					pg = '0;
				else
					pg = '1;
				issue_ref(pg, pick_gap(idle_ok), 1'b0, none);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 32'h0, pending_results.size());

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
